// File: src/epoch_timestamp_check_unit_macros.svh
// Assertion macros for the epoch timestamp check unit.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef EPOCH_TIMESTAMP_CHECK_UNIT_MACROS_SVH
`define EPOCH_TIMESTAMP_CHECK_UNIT_MACROS_SVH

// same-cycle implication
`define ETC_ASSERT_NOW(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("etc assertion failed");

// next-cycle implication
`define ETC_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("etc assertion failed");

`endif

// File: src/etc_pkg.sv
// Shared types, constants and the cumulative day table of the epoch timestamp check unit.
// No dependencies.
package etc_pkg;

   localparam int STAMP_W = 44;
   localparam int ZONE_W  = 5;
   localparam int DAYS_W  = 17;
   localparam int YEAR_W  = 12;

   localparam logic [STAMP_W-1:0] SEC_LO = 44'd1000000000;
   localparam logic [STAMP_W-1:0] SEC_HI = 44'd10000000000;
   localparam logic [STAMP_W-1:0] MS_LO  = 44'd1000000000000;
   localparam logic [STAMP_W-1:0] MS_HI  = 44'd10000000000000;

   // constant divides: x / d = (x * m) >> s for any x below 2**RCP_X_W
   localparam int RCP_X_W = 27;
   localparam int RCP_M_W = 28;
   localparam int RCP_P_W = RCP_X_W + RCP_M_W;
   localparam int RCP_Q_W = 22;
   localparam int DIV_D_W = 12;
   localparam int QHI_W   = 15;

   // 1000 = 8 * 125, 86400 = 128 * 675
   localparam int MS_SHIFT  = 3;
   localparam int MS_SPLIT  = 20;
   localparam int DAY_SHIFT = 7;

   localparam logic [DIV_D_W-1:0] DIV_MS_D   = 12'd125;
   localparam logic [DIV_D_W-1:0] DIV_DAY_D  = 12'd675;
   localparam logic [DIV_D_W-1:0] DIV_HOUR_D = 12'd3600;
   localparam logic [DIV_D_W-1:0] DIV_MIN_D  = 12'd60;

   localparam int DIV_MS_S   = 34;
   localparam int DIV_DAY_S  = 37;
   localparam int DIV_HOUR_S = 39;
   localparam int DIV_MIN_S  = 33;

   localparam logic [RCP_M_W-1:0] DIV_MS_M =
      RCP_M_W'(((64'd1 << DIV_MS_S) + 64'(DIV_MS_D) - 64'd1) / 64'(DIV_MS_D));
   localparam logic [RCP_M_W-1:0] DIV_DAY_M =
      RCP_M_W'(((64'd1 << DIV_DAY_S) + 64'(DIV_DAY_D) - 64'd1) / 64'(DIV_DAY_D));
   localparam logic [RCP_M_W-1:0] DIV_HOUR_M =
      RCP_M_W'(((64'd1 << DIV_HOUR_S) + 64'(DIV_HOUR_D) - 64'd1) / 64'(DIV_HOUR_D));
   localparam logic [RCP_M_W-1:0] DIV_MIN_M =
      RCP_M_W'(((64'd1 << DIV_MIN_S) + 64'(DIV_MIN_D) - 64'd1) / 64'(DIV_MIN_D));

   localparam logic [YEAR_W-1:0] BASE_YEAR   = 12'd1970;
   localparam logic [YEAR_W-1:0] LAST_YEAR   = 12'd2099;
   localparam logic [6:0]        BASE_MOD100 = 7'd70;
   localparam logic [8:0]        BASE_MOD400 = 9'd370;
   localparam logic [ZONE_W-1:0] ZONE_RESET  = 5'd8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLASS, ST_MS_GO, ST_MS_WAIT, ST_ZONE, ST_DAY_GO, ST_DAY_WAIT,
      ST_YEAR, ST_MONTH, ST_HR_GO, ST_HR_WAIT, ST_MIN_GO, ST_MIN_WAIT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {DIV_MS, DIV_DAY, DIV_HOUR, DIV_MIN} div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_take;
      logic        add_zone;
      logic        year_step;
      logic        month_step;
      logic        month_fin;
      logic        capture;
   } cmd_type;

   typedef struct packed {
      logic fmt_bad;
      logic fmt_ms;
      logic div_busy;
      logic year_done;
      logic month_done;
   } status_type;

   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         4'd12:   base = 9'd365;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && idx >= 4'd2 && idx <= 4'd12) ? 1 : 0);
   endfunction

endpackage

// File: src/etc_if.sv
// Channel interfaces of the epoch timestamp check unit: request, response, csr write.
// Depends on etc_pkg.
interface etc_req_if import etc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAMP_W-1:0] stamp;
   modport source (output valid, output stamp, input ready);
   modport sink   (input valid, input stamp, output ready);
endinterface

interface etc_rsp_if import etc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              valid_res;
   logic [YEAR_W-1:0] year_out;
   logic [3:0]        month_out;
   logic [4:0]        day_out;
   logic [4:0]        hour_out;
   logic [5:0]        minute_out;
   logic [5:0]        second_out;
   modport source (output valid, output valid_res, output year_out, output month_out,
                   output day_out, output hour_out, output minute_out, output second_out,
                   input ready);
   modport sink   (input valid, input valid_res, input year_out, input month_out,
                   input day_out, input hour_out, input minute_out, input second_out,
                   output ready);
endinterface

interface etc_csr_if import etc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ZONE_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/etc_div.sv
// Constant divider by reciprocal multiplication: the quotient is registered first, the remainder in the next cycle.
// Milliseconds take two such passes. Depends on etc_pkg.
module etc_div import etc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  div_sel_type        sel,
   input  logic [STAMP_W-1:0] dividend,
   output logic               busy,
   output logic [STAMP_W-1:0] quotient,
   output logic [DAYS_W-1:0]  remainder
);
   logic               busy_ff, busy_in;
   logic               phase_ff, phase_in;
   logic               pass_ff, pass_in;
   div_sel_type        sel_ff, sel_in;
   logic [STAMP_W-1:0] num_ff, num_in;
   logic [RCP_Q_W-1:0] q_ff, q_in;
   logic [QHI_W-1:0]   qhi_ff, qhi_in;
   logic [DAYS_W-1:0]  rem_ff, rem_in;
   logic [RCP_X_W-1:0] x;
   logic [RCP_M_W-1:0] m;
   logic [DIV_D_W-1:0] d;
   logic [RCP_P_W-1:0] prod;
   logic [RCP_Q_W-1:0] q_est;
   logic [RCP_X_W-1:0] rx;

   always_comb begin
      case (sel_ff)
         DIV_MS: begin
            // high part first, then its remainder joined to the low part
            x = pass_ff ? {rem_ff[6:0], num_ff[MS_SHIFT+MS_SPLIT-1:MS_SHIFT]}
                        : RCP_X_W'(num_ff[STAMP_W-1:MS_SHIFT+MS_SPLIT]);
            m = DIV_MS_M;
            d = DIV_MS_D;
         end
         DIV_DAY: begin
            x = num_ff[DAY_SHIFT+RCP_X_W-1:DAY_SHIFT];
            m = DIV_DAY_M;
            d = DIV_DAY_D;
         end
         DIV_HOUR: begin
            x = RCP_X_W'(num_ff[DAYS_W-1:0]);
            m = DIV_HOUR_M;
            d = DIV_HOUR_D;
         end
         DIV_MIN: begin
            x = RCP_X_W'(num_ff[DAYS_W-1:0]);
            m = DIV_MIN_M;
            d = DIV_MIN_D;
         end
         default: begin
            x = '0;
            m = '0;
            d = '0;
         end
      endcase
      prod = RCP_P_W'(x) * RCP_P_W'(m);
      case (sel_ff)
         DIV_MS:   q_est = RCP_Q_W'(prod >> DIV_MS_S);
         DIV_DAY:  q_est = RCP_Q_W'(prod >> DIV_DAY_S);
         DIV_HOUR: q_est = RCP_Q_W'(prod >> DIV_HOUR_S);
         DIV_MIN:  q_est = RCP_Q_W'(prod >> DIV_MIN_S);
         default:  q_est = '0;
      endcase
      rx = x - RCP_X_W'(RCP_X_W'(q_ff) * RCP_X_W'(d));
   end

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      pass_in  = pass_ff;
      sel_in   = sel_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      qhi_in   = qhi_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         pass_in  = 1'b0;
         sel_in   = sel;
         num_in   = dividend;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            q_in     = q_est;
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (sel_ff == DIV_DAY) rem_in = {rx[9:0], num_ff[DAY_SHIFT-1:0]};
            else                   rem_in = DAYS_W'(rx);
            if (sel_ff == DIV_MS && !pass_ff) begin
               qhi_in  = q_ff[QHI_W-1:0];
               pass_in = 1'b1;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         pass_ff  <= pass_in;
      end
      sel_ff <= sel_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      qhi_ff <= qhi_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = (sel_ff == DIV_MS) ? STAMP_W'({qhi_ff, q_ff[MS_SPLIT-1:0]})
                                         : STAMP_W'(q_ff);
   assign remainder = rem_ff;
endmodule

// File: src/etc_dpath.sv
// Datapath: zone register, working registers, year and month walk, result register.
// Depends on etc_pkg and etc_div.
module etc_dpath import etc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_we,
   input  logic [ZONE_W-1:0]  csr_data,
   input  logic [STAMP_W-1:0] stamp,
   output logic               valid_res,
   output logic [YEAR_W-1:0]  year_out,
   output logic [3:0]         month_out,
   output logic [4:0]         day_out,
   output logic [4:0]         hour_out,
   output logic [5:0]         minute_out,
   output logic [5:0]         second_out
);
   logic [ZONE_W-1:0]  zone_ff;
   logic [STAMP_W-1:0] t_ff;
   logic               bad_ff, ms_ff;
   logic [DAYS_W-1:0]  days_ff, clk_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [6:0]         c100_ff;
   logic [8:0]         c400_ff;
   logic [3:0]         month_ff;
   logic [4:0]         hour_ff;
   logic [5:0]         minute_ff, second_ff;

   logic               leap;
   logic [8:0]         ylen;
   logic [8:0]         next_cum;
   logic signed [17:0] zone_secs;
   logic [STAMP_W-1:0] div_dividend, div_q;
   logic [DAYS_W-1:0]  div_r;
   logic               div_busy;

   etc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .sel       (cmd.div_sel),
      .dividend  (div_dividend),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      case (cmd.div_sel)
         DIV_MS:   div_dividend = t_ff;
         DIV_DAY:  div_dividend = t_ff;
         DIV_HOUR: div_dividend = STAMP_W'(clk_ff);
         DIV_MIN:  div_dividend = STAMP_W'(clk_ff);
         default:  div_dividend = t_ff;
      endcase
   end

   assign leap      = (year_ff[1:0] == 2'd0 && c100_ff != 7'd0) || c400_ff == 9'd0;
   assign ylen      = leap ? 9'd366 : 9'd365;
   assign next_cum  = cum_days(leap, month_ff + 4'd1);
   assign zone_secs = 18'($signed(zone_ff)) * 18'sd3600;

   assign status.fmt_bad    = bad_ff;
   assign status.fmt_ms     = ms_ff;
   assign status.div_busy   = div_busy;
   assign status.year_done  = days_ff < DAYS_W'(ylen);
   assign status.month_done = !(month_ff < 4'd11 && days_ff >= DAYS_W'(next_cum));

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else if (csr_we) begin
         zone_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff   <= stamp;
         ms_ff  <= stamp >= MS_LO && stamp < MS_HI;
         bad_ff <= !((stamp >= SEC_LO && stamp < SEC_HI) || (stamp >= MS_LO && stamp < MS_HI));
      end
      if (cmd.add_zone) begin
         t_ff <= t_ff + STAMP_W'(zone_secs);
      end
      if (cmd.div_take) begin
         case (cmd.div_sel)
            DIV_MS: begin
               t_ff <= div_q;
            end
            DIV_DAY: begin
               days_ff  <= div_q[DAYS_W-1:0];
               clk_ff   <= div_r;
               year_ff  <= BASE_YEAR;
               c100_ff  <= BASE_MOD100;
               c400_ff  <= BASE_MOD400;
               month_ff <= 4'd0;
            end
            DIV_HOUR: begin
               hour_ff <= div_q[4:0];
               clk_ff  <= div_r;
            end
            DIV_MIN: begin
               minute_ff <= div_q[5:0];
               second_ff <= div_r[5:0];
            end
            default: begin
            end
         endcase
      end
      // walk one year per cycle from the base year
      if (cmd.year_step) begin
         days_ff <= days_ff - DAYS_W'(ylen);
         year_ff <= year_ff + 1'b1;
         c100_ff <= (c100_ff == 7'd99) ? 7'd0 : c100_ff + 1'b1;
         c400_ff <= (c400_ff == 9'd399) ? 9'd0 : c400_ff + 1'b1;
      end
      if (cmd.month_step) begin
         month_ff <= month_ff + 1'b1;
      end
      if (cmd.month_fin) begin
         days_ff <= days_ff - DAYS_W'(cum_days(leap, month_ff));
      end
      if (cmd.capture) begin
         if (bad_ff) begin
            valid_res  <= 1'b0;
            year_out   <= '0;
            month_out  <= '0;
            day_out    <= '0;
            hour_out   <= '0;
            minute_out <= '0;
            second_out <= '0;
         end else begin
            valid_res  <= year_ff >= BASE_YEAR && year_ff <= LAST_YEAR;
            year_out   <= year_ff;
            month_out  <= month_ff + 4'd1;
            day_out    <= 5'(days_ff + 1'b1);
            hour_out   <= hour_ff;
            minute_out <= minute_ff;
            second_out <= second_ff;
         end
      end
   end
endmodule

// File: src/etc_ctrl.sv
// Controller state machine: sequences divides, year and month walks, result handoff.
// Depends on etc_pkg.
module etc_ctrl import etc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CLASS;
         ST_CLASS: begin
            if (status.fmt_bad)     state_in = ST_DONE;
            else if (status.fmt_ms) state_in = ST_MS_GO;
            else                    state_in = ST_ZONE;
         end
         ST_MS_GO:    state_in = ST_MS_WAIT;
         ST_MS_WAIT:  if (!status.div_busy) state_in = ST_ZONE;
         ST_ZONE:     state_in = ST_DAY_GO;
         ST_DAY_GO:   state_in = ST_DAY_WAIT;
         ST_DAY_WAIT: if (!status.div_busy) state_in = ST_YEAR;
         ST_YEAR:     if (status.year_done) state_in = ST_MONTH;
         ST_MONTH:    if (status.month_done) state_in = ST_HR_GO;
         ST_HR_GO:    state_in = ST_HR_WAIT;
         ST_HR_WAIT:  if (!status.div_busy) state_in = ST_MIN_GO;
         ST_MIN_GO:   state_in = ST_MIN_WAIT;
         ST_MIN_WAIT: if (!status.div_busy) state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = DIV_DAY;
      case (state_ff)
         ST_IDLE:     cmd.load = req_valid;
         ST_MS_GO:    begin cmd.div_sel = DIV_MS; cmd.div_start = 1'b1; end
         ST_MS_WAIT:  begin cmd.div_sel = DIV_MS; cmd.div_take = !status.div_busy; end
         ST_ZONE:     cmd.add_zone = 1'b1;
         ST_DAY_GO:   cmd.div_start = 1'b1;
         ST_DAY_WAIT: cmd.div_take = !status.div_busy;
         ST_YEAR:     cmd.year_step = !status.year_done;
         ST_MONTH: begin
            cmd.month_step = !status.month_done;
            cmd.month_fin  = status.month_done;
         end
         ST_HR_GO:    begin cmd.div_sel = DIV_HOUR; cmd.div_start = 1'b1; end
         ST_HR_WAIT:  begin cmd.div_sel = DIV_HOUR; cmd.div_take = !status.div_busy; end
         ST_MIN_GO:   begin cmd.div_sel = DIV_MIN; cmd.div_start = 1'b1; end
         ST_MIN_WAIT: begin cmd.div_sel = DIV_MIN; cmd.div_take = !status.div_busy; end
         ST_DONE:     cmd.capture = out_free;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// File: src/epoch_timestamp_check_unit.sv
// Epoch timestamp check unit: one request at a time, one response per request.
// A stamp with a wrong digit count goes straight to the response; otherwise the run takes an extra
// divide pass for milliseconds and grows with the years since 1970 (up to 316) and the month index
// (up to 11), set by the one-year-per-cycle walk. A new request is taken in the cycle after the response
// is loaded; the response register holds a result while the next request is accepted.
// Synchronous active-high reset idles the controller and sets the zone offset to 8 hours.
module epoch_timestamp_check_unit import etc_pkg::*; (
   input logic       clock,
   input logic       reset,
   etc_req_if.sink   req_chan,
   etc_rsp_if.source rsp_chan,
   etc_csr_if.sink   csr_chan
);
   `include "epoch_timestamp_check_unit_macros.svh"

   cmd_type    cmd;
   status_type status;

   assign csr_chan.ready = 1'b1;

   etc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_chan.valid),
      .csr_data   (csr_chan.data),
      .stamp      (req_chan.stamp),
      .valid_res  (rsp_chan.valid_res),
      .year_out   (rsp_chan.year_out),
      .month_out  (rsp_chan.month_out),
      .day_out    (rsp_chan.day_out),
      .hour_out   (rsp_chan.hour_out),
      .minute_out (rsp_chan.minute_out),
      .second_out (rsp_chan.second_out)
   );

   `ETC_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `ETC_ASSERT_NOW(a_capture_free, cmd.capture, !rsp_chan.valid || rsp_chan.ready)
   `ETC_ASSERT_NOW(a_valid_year, rsp_chan.valid && rsp_chan.valid_res,
      rsp_chan.year_out >= BASE_YEAR && rsp_chan.year_out <= LAST_YEAR)
   `ETC_ASSERT_NOW(a_valid_date, rsp_chan.valid && rsp_chan.valid_res,
      rsp_chan.month_out >= 4'd1 && rsp_chan.month_out <= 4'd12 && rsp_chan.day_out != 5'd0)
endmodule

// File: dv/tb.sv
// Self-checking testbench for the epoch timestamp check unit.
// Depends on etc_pkg, the channel interfaces in etc_if.sv and the unit itself.
// Predicts each calendar date from the stamp and the zone offset.
typedef struct packed {
   logic        valid_res;
   logic [11:0] year_out;
   logic [3:0]  month_out;
   logic [4:0]  day_out;
   logic [4:0]  hour_out;
   logic [5:0]  minute_out;
   logic [5:0]  second_out;
} date_fields_type;

module tb;
   import etc_pkg::*;

   class date_scoreboard;
      date_fields_type    dates_due[$];
      logic signed [4:0]  zone_hours = 5'sd8;
      int                 errors = 0;

      function int is_leap(longint y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function date_fields_type to_calendar(logic [STAMP_W-1:0] s);
         int              cum[2][13] = '{'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
                                         '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}};
         date_fields_type r;
         longint          t, days, clk, est, y;
         int              lp, m;
         r = '0;
         if (s >= SEC_LO && s < SEC_HI) t = longint'(s);
         else if (s >= MS_LO && s < MS_HI) t = longint'(s) / 1000;
         else return r;
         t = t + longint'(zone_hours) * 3600;
         days = t / 86400;
         clk = t % 86400;
         est = days / 366;
         days = days - (est * 365 + (est + 1) / 4 - (est + 69) / 100 + (est + 369) / 400);
         y = est + 1970;
         forever begin
            lp = is_leap(y);
            if (days < cum[lp][12]) break;
            days = days - cum[lp][12];
            y++;
         end
         m = 0;
         while (m < 11 && days >= cum[lp][m + 1]) m++;
         days = days - cum[lp][m];
         r.valid_res  = (y >= 1970 && y <= 2099);
         r.year_out   = 12'(y);
         r.month_out  = 4'(m + 1);
         r.day_out    = 5'(days + 1);
         r.hour_out   = 5'(clk / 3600);
         r.minute_out = 6'((clk % 3600) / 60);
         r.second_out = 6'(clk % 60);
         return r;
      endfunction

      function void note_stamp(logic [STAMP_W-1:0] s);
         dates_due.push_back(to_calendar(s));
      endfunction

      function void check_date(date_fields_type got);
         date_fields_type exp_d;
         if (dates_due.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         exp_d = dates_due.pop_front();
         if (got.valid_res !== exp_d.valid_res) begin
            $error("valid_res: expected %0d actual %0d", exp_d.valid_res, got.valid_res);
            errors++;
         end
         if (got.year_out !== exp_d.year_out) begin
            $error("year_out: expected %0d actual %0d", exp_d.year_out, got.year_out);
            errors++;
         end
         if (got.month_out !== exp_d.month_out) begin
            $error("month_out: expected %0d actual %0d", exp_d.month_out, got.month_out);
            errors++;
         end
         if (got.day_out !== exp_d.day_out) begin
            $error("day_out: expected %0d actual %0d", exp_d.day_out, got.day_out);
            errors++;
         end
         if (got.hour_out !== exp_d.hour_out) begin
            $error("hour_out: expected %0d actual %0d", exp_d.hour_out, got.hour_out);
            errors++;
         end
         if (got.minute_out !== exp_d.minute_out) begin
            $error("minute_out: expected %0d actual %0d", exp_d.minute_out, got.minute_out);
            errors++;
         end
         if (got.second_out !== exp_d.second_out) begin
            $error("second_out: expected %0d actual %0d", exp_d.second_out, got.second_out);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   rsp_hold;

   etc_req_if req_chan();
   etc_rsp_if rsp_chan();
   etc_csr_if csr_chan();

   date_scoreboard sb = new();

   epoch_timestamp_check_unit DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: random stalls, or a long counted hold-off when asked
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_chan.ready = 1'b0;
            rsp_hold--;
         end else begin
            rsp_chan.ready = calm ? 1'b1 : ($urandom_range(99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_date({rsp_chan.valid_res, rsp_chan.year_out, rsp_chan.month_out,
                        rsp_chan.day_out, rsp_chan.hour_out, rsp_chan.minute_out,
                        rsp_chan.second_out});
   end

   task automatic send_stamp(logic [STAMP_W-1:0] s);
      while (!calm && $urandom_range(99) < 34) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.stamp = s;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_stamp(s);
      @(negedge clock);
   endtask

   task automatic drain;
      req_chan.valid = 1'b0;
      while (sb.dates_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_zone(logic [ZONE_W-1:0] z);
      csr_chan.valid = 1'b1;
      csr_chan.data  = z;
      do @(posedge clock); while (!csr_chan.ready);
      sb.zone_hours = z;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   function automatic logic [STAMP_W-1:0] random_stamp();
      logic [63:0] raw;
      int          pick;
      raw  = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 40) return 44'(SEC_LO + raw % (SEC_HI - SEC_LO));
      if (pick < 80) return 44'(MS_LO + raw % (MS_HI - MS_LO));
      return raw[STAMP_W-1:0];
   endfunction

   logic [STAMP_W-1:0] directed[$] = '{
      44'd0, 44'd999999999, 44'd1000000000, 44'd9999999999, 44'd10000000000,
      44'd999999999999, 44'd1000000000000, 44'd9999999999999, 44'd10000000000000,
      44'hFFFFFFFFFFF, 44'd4102444799, 44'd4102444800, 44'd4107542399,
      44'd1078012800, 44'd1709164800, 44'd1709164799999, 44'd4102444799999,
      44'd1234567890, 44'd1234567890123, 44'd1000000000999, 44'd1577836799
   };

   logic [ZONE_W-1:0] zones[7] = '{5'd8, 5'd16, 5'd15, 5'd20, 5'd14, 5'd0, 5'd3};

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      rsp_hold = 0;
      req_chan.valid = 1'b0;
      req_chan.stamp = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      foreach (zones[p]) begin
         write_zone(p == 6 ? ZONE_W'($urandom_range(31)) : zones[p]);
         foreach (directed[i]) send_stamp(directed[i]);
         calm = (p == 4);
         // hold off the response side so the unit fills and stalls its input
         if (p == 1) rsp_hold = 3000;
         for (int n = 0; n < 180; n++) send_stamp(random_stamp());
         calm = 1'b0;
         drain();
      end
      repeat (600) @(negedge clock);
      if (sb.errors == 0 && sb.dates_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: files.f
+incdir+src
src/etc_pkg.sv
src/etc_if.sv
src/etc_div.sv
src/etc_dpath.sv
src/etc_ctrl.sv
src/epoch_timestamp_check_unit.sv
dv/tb.sv
